FILE: rtl/sasf_pkg.sv
`default_nettype none
package sasf_pkg;

  localparam int COORD_W     = 32;
  localparam int FRAC_BITS   = 16;
  localparam int WEIGHT_FRAC = 8;

  // pipeline depths of the iterative units, one result bit per stage
  localparam int SQRT_STEPS  = 32;
  localparam int DIV_STEPS   = 31;
  localparam int SPEED_STEPS = 40;

  localparam logic [31:0] STOP_RADIUS = 32'd20 << FRAC_BITS;

  localparam logic [2:0] REG_ENABLES   = 3'd0;
  localparam logic [2:0] REG_W_SEEK    = 3'd1;
  localparam logic [2:0] REG_W_ARRIVE  = 3'd2;
  localparam logic [2:0] REG_DECEL     = 3'd3;
  localparam logic [2:0] REG_MAX_SPEED = 3'd4;
  localparam logic [2:0] REG_MAX_FORCE = 3'd5;

  typedef struct packed {
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
    logic signed [COORD_W-1:0] position_x;
    logic signed [COORD_W-1:0] position_y;
    logic signed [COORD_W-1:0] position_z;
    logic signed [COORD_W-1:0] velocity_x;
    logic signed [COORD_W-1:0] velocity_y;
    logic signed [COORD_W-1:0] velocity_z;
  } agent_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] force_x;
    logic signed [COORD_W-1:0] force_y;
    logic signed [COORD_W-1:0] force_z;
    logic                      force_was_limited;
    logic                      within_stop_radius;
  } steer_t;

endpackage
`default_nettype wire

FILE: rtl/sasf_sqrt.sv
`default_nettype none
module sasf_sqrt import sasf_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [63:0] radicand,
  output logic [31:0] root
);

  logic [33:0] rem  [SQRT_STEPS];
  logic [31:0] rt   [SQRT_STEPS];
  logic [63:0] rest [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
    logic [33:0] rem_in;
    logic [31:0] rt_in;
    logic [63:0] rest_in;
    logic [35:0] t;
    logic [35:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign rt_in   = '0;
      assign rest_in = radicand;
    end else begin : g_next
      assign rem_in  = rem[k-1];
      assign rt_in   = rt[k-1];
      assign rest_in = rest[k-1];
    end

    assign t     = {rem_in, rest_in[63:62]};
    assign trial = {2'b00, rt_in, 2'b01};
    assign ge    = (t >= trial);

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k]  <= ge ? 34'(t - trial) : t[33:0];
        rt[k]   <= {rt_in[30:0], ge};
        rest[k] <= {rest_in[61:0], 2'b00};
      end
    end
  end

  assign root = rt[SQRT_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/sasf_div.sv
`default_nettype none
module sasf_div import sasf_pkg::*; (
  input  logic        clk,
  input  logic        adv,
  input  logic [62:0] num,
  input  logic [31:0] den,
  output logic [30:0] quo
);

  // quotient is known to fit 31 bits, so the top word starts as the remainder
  logic [31:0] rem [DIV_STEPS];
  logic [30:0] lo  [DIV_STEPS];
  logic [30:0] q   [DIV_STEPS];
  logic [31:0] dv  [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [31:0] rem_in;
    logic [30:0] lo_in;
    logic [30:0] q_in;
    logic [31:0] dv_in;
    logic [32:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = num[62:31];
      assign lo_in  = num[30:0];
      assign q_in   = '0;
      assign dv_in  = den;
    end else begin : g_next
      assign rem_in = rem[k-1];
      assign lo_in  = lo[k-1];
      assign q_in   = q[k-1];
      assign dv_in  = dv[k-1];
    end

    assign t  = {rem_in, lo_in[30]};
    assign ge = (t >= {1'b0, dv_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[k] <= ge ? 32'(t - {1'b0, dv_in}) : t[31:0];
        lo[k]  <= {lo_in[29:0], 1'b0};
        q[k]   <= {q_in[29:0], ge};
        dv[k]  <= dv_in;
      end
    end
  end

  assign quo = q[DIV_STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/seek_arrive_steering_force.sv
`default_nettype none
// Channel  Dir  Handshake                 Payload
// agent    in   agent_valid/agent_stall   agent_t: target, position, velocity
// steer    out  steer_valid/steer_stall   steer_t: force, limited, within flags
// apb      in   psel/penable/pwrite       paddr[4:2] register, pwdata/prdata
//
// One beat enters per cycle while agent_stall is low. The depth is set by
// two 32-stage square roots, a 40-stage arrive speed divider and two
// 31-stage scaling dividers in series.
// rst is synchronous and clears every valid bit and the registers to defaults.
// A stall freezes the pipe only when the last stage holds a beat; bubbles keep
// draining, so input beats are still taken while a result waits.
module seek_arrive_steering_force import sasf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        agent_valid,
  output logic        agent_stall,
  input  agent_t      agent,
  output logic        steer_valid,
  input  logic        steer_stall,
  output steer_t      steer,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  typedef logic [2:0][31:0] vec_t;

  typedef struct packed {
    logic vld;
    vec_t d;
    vec_t vel;
  } a_t;

  typedef struct packed {
    logic        vld;
    vec_t        d;
    vec_t        vel;
    logic [31:0] distance;
    logic        in_radius;
  } c_t;

  typedef struct packed {
    logic       vld;
    logic [2:0] dneg;
    vec_t       vel;
    logic       dzero;
    logic       in_radius;
  } m_t;

  typedef struct packed {
    logic vld;
    logic in_radius;
    vec_t s;
    vec_t a;
  } g_t;

  typedef struct packed {
    logic vld;
    logic in_radius;
    logic limited;
    vec_t f;
  } k_t;

  function automatic logic [31:0] sat40(input logic [39:0] v);
    logic [31:0] r;
    if (v[39:31] == 9'h000 || v[39:31] == 9'h1FF) r = v[31:0];
    else if (v[39]) r = 32'h8000_0000;
    else r = 32'h7FFF_FFFF;
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic [31:0] c);
    return c[31] ? (~c + 32'd1) : c;
  endfunction

  // ---------------- configuration ----------------
  logic [1:0]  behavior_enables;
  logic [15:0] weight_seek;
  logic [15:0] weight_arrive;
  logic [15:0] decel_divisor;
  logic [30:0] max_speed;
  logic [30:0] max_force;
  logic [61:0] mf2;

  always_ff @(posedge clk) begin
    if (rst) begin
      behavior_enables <= 2'd1;
      weight_seek      <= 16'd256;
      weight_arrive    <= 16'd256;
      decel_divisor    <= 16'd768;
      max_speed        <= 31'd6553600;
      max_force        <= 31'd6553600;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ENABLES:   behavior_enables <= pwdata[1:0];
        REG_W_SEEK:    weight_seek      <= pwdata[15:0];
        REG_W_ARRIVE:  weight_arrive    <= pwdata[15:0];
        REG_DECEL:     decel_divisor    <= pwdata[15:0];
        REG_MAX_SPEED: max_speed        <= pwdata[30:0];
        REG_MAX_FORCE: max_force        <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mf2 <= 62'(max_force) * 62'(max_force);
  end

  always_comb begin
    case (paddr[4:2])
      REG_ENABLES:   prdata = {30'd0, behavior_enables};
      REG_W_SEEK:    prdata = {16'd0, weight_seek};
      REG_W_ARRIVE:  prdata = {16'd0, weight_arrive};
      REG_DECEL:     prdata = {16'd0, decel_divisor};
      REG_MAX_SPEED: prdata = {1'b0, max_speed};
      REG_MAX_FORCE: prdata = {1'b0, max_force};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- flow control ----------------
  logic   adv;
  logic   o_vld;
  steer_t o_data;
  k_t     pl [DIV_STEPS];

  assign adv         = !o_vld || !steer_stall || !pl[DIV_STEPS-1].vld;
  assign agent_stall = !adv;

  // ---------------- offset and squared distance ----------------
  a_t          a_r, a_next;
  logic [2:0][63:0] sq_r;
  a_t          sq_ctx;
  logic [63:0] ss_sum;
  a_t          ss_ctx;

  always_comb begin
    a_next.vld = agent_valid;
    a_next.d[0] = sat40(40'(agent.target_x) - 40'(agent.position_x));
    a_next.d[1] = sat40(40'(agent.target_y) - 40'(agent.position_y));
    a_next.d[2] = sat40(40'(agent.target_z) - 40'(agent.position_z));
    a_next.vel[0] = agent.velocity_x;
    a_next.vel[1] = agent.velocity_y;
    a_next.vel[2] = agent.velocity_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_r.vld    <= 1'b0;
      sq_ctx.vld <= 1'b0;
      ss_ctx.vld <= 1'b0;
    end else if (adv) begin
      a_r    <= a_next;
      sq_ctx <= a_r;
      ss_ctx <= sq_ctx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 64'(mag32(a_r.d[i])) * 64'(mag32(a_r.d[i]));
      end
      ss_sum <= sq_r[0] + sq_r[1] + sq_r[2];
    end
  end

  logic [31:0] dist_root;
  a_t          bl [SQRT_STEPS];

  sasf_sqrt u_dist_sqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (ss_sum),
    .root     (dist_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) bl[k].vld <= 1'b0;
    end else if (adv) begin
      bl[0] <= ss_ctx;
      for (int k = 1; k < SQRT_STEPS; k++) bl[k] <= bl[k-1];
    end
  end

  // ---------------- distance and arrive speed ----------------
  c_t c_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_r.vld <= 1'b0;
    end else if (adv) begin
      c_r.vld       <= bl[SQRT_STEPS-1].vld;
      c_r.d         <= bl[SQRT_STEPS-1].d;
      c_r.vel       <= bl[SQRT_STEPS-1].vel;
      c_r.distance  <= dist_root;
      c_r.in_radius <= (dist_root <= STOP_RADIUS);
    end
  end

  logic [15:0] sp_rem [SPEED_STEPS];
  logic [39:0] sp_num [SPEED_STEPS];
  logic [39:0] sp_q   [SPEED_STEPS];
  c_t          cl     [SPEED_STEPS];

  for (genvar k = 0; k < SPEED_STEPS; k++) begin : g_spd
    logic [15:0] rem_in;
    logic [39:0] num_in;
    logic [39:0] q_in;
    logic [16:0] t;
    logic        ge;

    if (k == 0) begin : g_first
      assign rem_in = '0;
      assign num_in = {c_r.distance, 8'h00};
      assign q_in   = '0;
    end else begin : g_next
      assign rem_in = sp_rem[k-1];
      assign num_in = sp_num[k-1];
      assign q_in   = sp_q[k-1];
    end

    assign t  = {rem_in, num_in[39]};
    assign ge = (t >= {1'b0, decel_divisor});

    always_ff @(posedge clk) begin
      if (adv) begin
        sp_rem[k] <= ge ? 16'(t - {1'b0, decel_divisor}) : t[15:0];
        sp_num[k] <= {num_in[38:0], 1'b0};
        sp_q[k]   <= {q_in[38:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SPEED_STEPS; k++) cl[k].vld <= 1'b0;
    end else if (adv) begin
      cl[0] <= c_r;
      for (int k = 1; k < SPEED_STEPS; k++) cl[k] <= cl[k-1];
    end
  end

  c_t          e_r;
  logic [30:0] e_speed;
  logic [39:0] spd_q;

  assign spd_q = sp_q[SPEED_STEPS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      e_r.vld <= 1'b0;
    end else if (adv) begin
      e_r <= cl[SPEED_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (decel_divisor == 16'd0 || spd_q > 40'(max_speed)) e_speed <= max_speed;
      else e_speed <= spd_q[30:0];
    end
  end

  // ---------------- desired velocity scaling ----------------
  m_t               m_r;
  logic [2:0][62:0] m_ps;
  logic [2:0][62:0] m_pa;
  logic [31:0]      m_dist;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_r.vld <= 1'b0;
    end else if (adv) begin
      m_r.vld       <= e_r.vld;
      m_r.vel       <= e_r.vel;
      m_r.dzero     <= (e_r.distance == 32'd0);
      m_r.in_radius <= e_r.in_radius;
      for (int i = 0; i < 3; i++) m_r.dneg[i] <= e_r.d[i][31];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_dist <= e_r.distance;
      for (int i = 0; i < 3; i++) begin
        m_ps[i] <= 63'(mag32(e_r.d[i])) * 63'(max_speed);
        m_pa[i] <= 63'(mag32(e_r.d[i])) * 63'(e_speed);
      end
    end
  end

  logic [2:0][30:0] qs;
  logic [2:0][30:0] qa;
  m_t               ml [DIV_STEPS];

  for (genvar i = 0; i < 3; i++) begin : g_des
    sasf_div u_seek_div (
      .clk (clk),
      .adv (adv),
      .num (m_ps[i]),
      .den (m_dist),
      .quo (qs[i])
    );
    sasf_div u_arrive_div (
      .clk (clk),
      .adv (adv),
      .num (m_pa[i]),
      .den (m_dist),
      .quo (qa[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) ml[k].vld <= 1'b0;
    end else if (adv) begin
      ml[0] <= m_r;
      for (int k = 1; k < DIV_STEPS; k++) ml[k] <= ml[k-1];
    end
  end

  // ---------------- weighting and sum ----------------
  m_t               ml_last;
  g_t               g_r, g_next;
  logic             w_vld, w_within;
  logic [2:0][47:0] w_s, w_a;
  g_t               h_r;
  k_t               f_r;

  assign ml_last = ml[DIV_STEPS-1];

  always_comb begin
    logic [39:0] des_s, des_a, vel40;
    g_next.vld       = ml_last.vld;
    g_next.in_radius = ml_last.in_radius;
    for (int i = 0; i < 3; i++) begin
      vel40 = 40'($signed(ml_last.vel[i]));
      des_s = ml_last.dneg[i] ? -40'(qs[i]) : 40'(qs[i]);
      if (ml_last.dzero) des_s = '0;
      des_a = ml_last.dneg[i] ? -40'(qa[i]) : 40'(qa[i]);
      g_next.s[i] = sat40(des_s - vel40);
      g_next.a[i] = sat40(des_a - vel40);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_r.vld <= 1'b0;
      w_vld   <= 1'b0;
      h_r.vld <= 1'b0;
      f_r.vld <= 1'b0;
    end else if (adv) begin
      g_r      <= g_next;
      w_vld    <= g_r.vld;
      w_within <= g_r.in_radius;
      h_r.vld  <= w_vld;
      h_r.in_radius <= w_within;
      f_r.vld       <= h_r.vld;
      f_r.in_radius <= h_r.in_radius;
      for (int i = 0; i < 3; i++) begin
        // bits 47:8 are the floor of the product over 256
        h_r.s[i] <= behavior_enables[0] ? sat40(w_s[i][47:8]) : 32'd0;
        h_r.a[i] <= (behavior_enables[1] && !w_within) ? sat40(w_a[i][47:8]) : 32'd0;
        f_r.f[i] <= sat40(40'($signed(h_r.s[i])) + 40'($signed(h_r.a[i])));
      end
      f_r.limited <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        w_s[i] <= 48'($signed(g_r.s[i])) * 48'($signed({1'b0, weight_seek}));
        w_a[i] <= 48'($signed(g_r.a[i])) * 48'($signed({1'b0, weight_arrive}));
      end
    end
  end

  // ---------------- force magnitude limit ----------------
  logic [2:0][63:0] fsq;
  k_t               fq_ctx;
  k_t               fs_ctx;
  logic [63:0]      fs_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      fq_ctx.vld <= 1'b0;
      fs_ctx.vld <= 1'b0;
    end else if (adv) begin
      fq_ctx            <= f_r;
      fs_ctx.vld        <= fq_ctx.vld;
      fs_ctx.in_radius  <= fq_ctx.in_radius;
      fs_ctx.f          <= fq_ctx.f;
      fs_ctx.limited    <= ((fsq[0] + fsq[1] + fsq[2]) > {2'b00, mf2});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) fsq[i] <= 64'(mag32(f_r.f[i])) * 64'(mag32(f_r.f[i]));
      fs_sum <= fsq[0] + fsq[1] + fsq[2];
    end
  end

  logic [31:0] mag_root;
  k_t          fl [SQRT_STEPS];

  sasf_sqrt u_mag_sqrt (
    .clk      (clk),
    .adv      (adv),
    .radicand (fs_sum),
    .root     (mag_root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SQRT_STEPS; k++) fl[k].vld <= 1'b0;
    end else if (adv) begin
      fl[0] <= fs_ctx;
      for (int k = 1; k < SQRT_STEPS; k++) fl[k] <= fl[k-1];
    end
  end

  k_t               k_r;
  logic [31:0]      k_mag;
  k_t               p_ctx;
  logic [31:0]      p_mag;
  logic [2:0][62:0] p_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      k_r.vld   <= 1'b0;
      p_ctx.vld <= 1'b0;
    end else if (adv) begin
      k_r   <= fl[SQRT_STEPS-1];
      p_ctx <= k_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k_mag <= mag_root;
      p_mag <= k_mag;
      for (int i = 0; i < 3; i++) p_prod[i] <= 63'(mag32(k_r.f[i])) * 63'(max_force);
    end
  end

  logic [2:0][30:0] lq;

  for (genvar i = 0; i < 3; i++) begin : g_lim
    sasf_div u_lim_div (
      .clk (clk),
      .adv (adv),
      .num (p_prod[i]),
      .den (p_mag),
      .quo (lq[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DIV_STEPS; k++) pl[k].vld <= 1'b0;
    end else if (adv) begin
      pl[0] <= p_ctx;
      for (int k = 1; k < DIV_STEPS; k++) pl[k] <= pl[k-1];
    end
  end

  // ---------------- output register ----------------
  k_t               pl_last;
  logic [2:0][31:0] fo;

  assign pl_last = pl[DIV_STEPS-1];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (pl_last.limited) fo[i] = pl_last.f[i][31] ? -{1'b0, lq[i]} : {1'b0, lq[i]};
      else fo[i] = pl_last.f[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_vld <= 1'b0;
    end else if (!o_vld || !steer_stall) begin
      o_vld                     <= pl_last.vld;
      o_data.force_x            <= fo[0];
      o_data.force_y            <= fo[1];
      o_data.force_z            <= fo[2];
      o_data.force_was_limited  <= pl_last.limited;
      o_data.within_stop_radius <= pl_last.in_radius;
    end
  end

  assign steer_valid = o_vld;
  assign steer       = o_data;

`ifndef SYNTHESIS
  a_halt_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !adv |-> (steer_valid && steer_stall))
    else $error("pipe halted without a blocked result");

  a_no_terms_zero: assert property (@(posedge clk) disable iff (rst)
    (steer_valid && (behavior_enables == 2'b00 ||
      (behavior_enables == 2'b10 && steer.within_stop_radius)))
    |-> (steer.force_x == 32'd0 && steer.force_y == 32'd0 && steer.force_z == 32'd0))
    else $error("force nonzero with no active term");

  a_speed_clamped: assert property (@(posedge clk) disable iff (rst)
    e_r.vld |-> (e_speed <= max_speed))
    else $error("arrive speed above max speed");

  a_limit_mag_nonzero: assert property (@(posedge clk) disable iff (rst)
    (k_r.vld && k_r.limited) |-> (mag_root != 32'd0 || k_mag != 32'd0))
    else $error("limited force with zero magnitude");
`endif

endmodule
`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

import sasf_pkg::*;

class steer_scoreboard;
  logic [1:0]  enables;
  logic [15:0] w_seek;
  logic [15:0] w_arrive;
  logic [15:0] decel;
  logic [30:0] max_speed;
  logic [30:0] max_force;
  steer_t      pending[$];
  int          mismatches;

  function new();
    enables   = 2'd1;
    w_seek    = 16'd256;
    w_arrive  = 16'd256;
    decel     = 16'd768;
    max_speed = 31'd6553600;
    max_force = 31'd6553600;
    mismatches = 0;
  endfunction

  static function longint clip(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  static function logic [63:0] isqrt(logic [127:0] n);
    logic [63:0]  r;
    logic [63:0]  t;
    logic [127:0] tt;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      tt = {64'd0, t} * {64'd0, t};
      if (tt <= n) r = t;
    end
    return r;
  endfunction

  static function logic [63:0] mag(longint c);
    return (c < 0) ? 64'(-c) : 64'(c);
  endfunction

  // c * num / den, truncated toward zero
  static function longint ratio(longint c, logic [63:0] num, logic [63:0] den);
    logic [127:0] p;
    logic [127:0] q;
    p = {64'd0, mag(c)} * {64'd0, num};
    q = p / {64'd0, den};
    return (c < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
  endfunction

  static function logic [127:0] sumsq(longint v[3]);
    logic [127:0] s;
    s = '0;
    for (int i = 0; i < 3; i++) s += {64'd0, mag(v[i])} * {64'd0, mag(v[i])};
    return s;
  endfunction

  // Q8.8 weight, floor
  static function longint apply_weight(longint term, logic [15:0] w);
    longint p;
    p = term * longint'({48'd0, w});
    return clip(p >>> 8);
  endfunction

  function steer_t steer_force(agent_t a);
    longint       d[3];
    longint       vel[3];
    longint       f[3];
    logic [63:0]  distance;
    logic [63:0]  speed;
    logic [63:0]  fmag;
    logic [127:0] s;
    longint       des;
    steer_t       r;
    d[0] = clip(longint'(a.target_x) - longint'(a.position_x));
    d[1] = clip(longint'(a.target_y) - longint'(a.position_y));
    d[2] = clip(longint'(a.target_z) - longint'(a.position_z));
    vel[0] = a.velocity_x;
    vel[1] = a.velocity_y;
    vel[2] = a.velocity_z;
    f = '{0, 0, 0};
    distance = isqrt(sumsq(d));
    r.within_stop_radius = (distance <= (64'd20 << 16));
    if (enables[0]) begin
      for (int i = 0; i < 3; i++) begin
        des = (distance != 0) ? ratio(d[i], {33'd0, max_speed}, distance) : 0;
        f[i] = clip(f[i] + apply_weight(clip(des - vel[i]), w_seek));
      end
    end
    if (enables[1] && !r.within_stop_radius) begin
      speed = (decel != 0) ? (distance << 8) / {48'd0, decel} : {33'd0, max_speed};
      if (speed > {33'd0, max_speed}) speed = {33'd0, max_speed};
      for (int i = 0; i < 3; i++) begin
        des = ratio(d[i], speed, distance);
        f[i] = clip(f[i] + apply_weight(clip(des - vel[i]), w_arrive));
      end
    end
    s = sumsq(f);
    r.force_was_limited = (s > {97'd0, max_force} * {97'd0, max_force});
    if (r.force_was_limited) begin
      fmag = isqrt(s);
      for (int i = 0; i < 3; i++) f[i] = ratio(f[i], {33'd0, max_force}, fmag);
    end
    r.force_x = f[0][31:0];
    r.force_y = f[1][31:0];
    r.force_z = f[2][31:0];
    return r;
  endfunction

  function void note_agent(agent_t a);
    pending.push_back(steer_force(a));
  endfunction

  function void check_steer(steer_t got);
    steer_t want;
    if (pending.size() == 0) begin
      $error("unexpected steer beat %h", got);
      mismatches++;
      return;
    end
    want = pending.pop_front();
    if (got.force_x !== want.force_x) begin
      $error("force_x: expected %0d, got %0d", want.force_x, got.force_x);
      mismatches++;
    end
    if (got.force_y !== want.force_y) begin
      $error("force_y: expected %0d, got %0d", want.force_y, got.force_y);
      mismatches++;
    end
    if (got.force_z !== want.force_z) begin
      $error("force_z: expected %0d, got %0d", want.force_z, got.force_z);
      mismatches++;
    end
    if (got.force_was_limited !== want.force_was_limited) begin
      $error("force_was_limited: expected %0b, got %0b",
             want.force_was_limited, got.force_was_limited);
      mismatches++;
    end
    if (got.within_stop_radius !== want.within_stop_radius) begin
      $error("within_stop_radius: expected %0b, got %0b",
             want.within_stop_radius, got.within_stop_radius);
      mismatches++;
    end
  endfunction
endclass

module testbench;
  import sasf_pkg::*;

  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASES = 8;
  localparam int RANDOM_ITEMS = 150;

  logic        clk = 1'b0;
  logic        rst;
  logic        agent_valid;
  logic        agent_stall;
  agent_t      agent;
  logic        steer_valid;
  logic        steer_stall;
  steer_t      steer;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          gap_pct;
  int          stall_pct;
  int          cycles;
  steer_scoreboard sb;

  seek_arrive_steering_force DUT (
    .clk(clk), .rst(rst),
    .agent_valid(agent_valid), .agent_stall(agent_stall), .agent(agent),
    .steer_valid(steer_valid), .steer_stall(steer_stall), .steer(steer),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    sb = new();
    gap_pct = 0;
    stall_pct = 0;
    cycles = 0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (agent_valid && !agent_stall) sb.note_agent(agent);
      if (steer_valid && !steer_stall) sb.check_steer(steer);
    end
    steer_stall <= ($urandom_range(99) < stall_pct);
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ENABLES:   sb.enables   = value[1:0];
      REG_W_SEEK:    sb.w_seek    = value[15:0];
      REG_W_ARRIVE:  sb.w_arrive  = value[15:0];
      REG_DECEL:     sb.decel     = value[15:0];
      REG_MAX_SPEED: sb.max_speed = value[30:0];
      REG_MAX_FORCE: sb.max_force = value[30:0];
      default: ;
    endcase
  endtask

  task automatic configure(logic [1:0] en, logic [15:0] ws, logic [15:0] wa,
                           logic [15:0] dec, logic [30:0] ms, logic [30:0] mf);
    write_reg(REG_ENABLES, {30'd0, en});
    write_reg(REG_W_SEEK, {16'd0, ws});
    write_reg(REG_W_ARRIVE, {16'd0, wa});
    write_reg(REG_DECEL, {16'd0, dec});
    write_reg(REG_MAX_SPEED, {1'b0, ms});
    write_reg(REG_MAX_FORCE, {1'b0, mf});
  endtask

  task automatic send(agent_t a);
    while ($urandom_range(99) < gap_pct) begin
      agent_valid <= 1'b0;
      @(posedge clk);
    end
    agent_valid <= 1'b1;
    agent <= a;
    do @(posedge clk); while (agent_stall);
  endtask

  function automatic logic [31:0] small_coord(int units);
    return 32'($signed($urandom_range(2 * units)) - units) <<< 16
           | 32'($urandom_range(65535));
  endfunction

  function automatic agent_t random_agent();
    agent_t a;
    a = {$urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(4))
      0: ;
      1: begin
        a.position_x = small_coord(1000);
        a.position_y = small_coord(1000);
        a.position_z = small_coord(1000);
        a.target_x = small_coord(1000);
        a.target_y = small_coord(1000);
        a.target_z = small_coord(1000);
      end
      2: begin
        // land near the stop radius
        a.target_x = a.position_x + small_coord(16);
        a.target_y = a.position_y + small_coord(16);
        a.target_z = a.position_z + small_coord(16);
      end
      3: begin
        a.target_x = a.position_x;
        a.target_y = a.position_y;
        a.target_z = a.position_z;
      end
      default: begin
        a.target_x = a.position_x + small_coord(200);
        a.target_y = a.position_y + small_coord(200);
        a.target_z = a.position_z + small_coord(200);
      end
    endcase
    if ($urandom_range(1)) begin
      a.velocity_x = small_coord(50);
      a.velocity_y = small_coord(50);
      a.velocity_z = small_coord(50);
    end
    return a;
  endfunction

  task automatic directed_items();
    agent_t a;
    a = '0;
    send(a);
    a = '1;
    send(a);
    a = '0;
    a.velocity_x = 32'sh7fffffff;
    a.velocity_y = 32'sh80000000;
    a.velocity_z = 32'sd65536;
    send(a);
    a = '0;
    a.target_x = 32'sh7fffffff;
    a.position_x = 32'sh80000000;
    a.target_y = 32'sh80000000;
    a.position_y = 32'sh7fffffff;
    a.target_z = 32'sh7fffffff;
    a.position_z = 32'sh80000000;
    send(a);
    a.velocity_x = 32'sh80000000;
    a.velocity_y = 32'sh7fffffff;
    send(a);
    a = '0;
    a.target_x = 32'sd20 <<< 16;
    send(a);
    a.target_x = (32'sd20 <<< 16) + 1;
    send(a);
    a.target_x = 32'sd5 <<< 16;
    a.velocity_z = -(32'sd3 <<< 16);
    send(a);
    a = '0;
    a.target_y = -(32'sd1000 <<< 16);
    a.position_z = 32'sd400 <<< 16;
    a.velocity_x = 32'sd7 <<< 16;
    send(a);
    a = {9{32'sh80000000}};
    send(a);
    a = {9{32'sh7fffffff}};
    send(a);
    a = '0;
    a.target_x = 32'sd1;
    send(a);
    a = '0;
    a.target_x = 32'sh55555555;
    a.target_y = 32'shaaaaaaaa;
    a.position_z = 32'sh55555555;
    a.velocity_y = 32'shaaaaaaaa;
    send(a);
  endtask

  task automatic drain();
    agent_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    rst         <= 1'b1;
    agent_valid <= 1'b0;
    agent       <= '0;
    steer_stall <= 1'b0;
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    paddr       <= '0;
    pwdata      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 49; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 49; end
        default: begin gap_pct = 6; stall_pct = 6; end
      endcase
      case (ph)
        0: configure(2'd3, 16'd256, 16'd256, 16'd768, 31'd100 << 16, 31'd50 << 16);
        1: begin
          configure(2'd1, 16'd256, 16'd256, 16'd768, 31'd6553600, 31'd6553600);
          write_reg(REG_UNUSED, $urandom);
        end
        2: configure(2'd2, 16'd0, 16'd65535, 16'd1, 31'h7fffffff, 31'h7fffffff);
        3: configure(2'd3, 16'd65535, 16'd65535, 16'd65535, 31'd0, 31'd0);
        4: configure(2'd3, 16'd65535, 16'd0, 16'd0, 31'h7fffffff, 31'd1 << 16);
        5: configure(2'd0, 16'd100, 16'd100, 16'd100, 31'd1000, 31'd1000);
        6: configure(2'd3, 16'($urandom), 16'($urandom), 16'($urandom),
                     31'($urandom), 31'($urandom));
        default: configure(2'd2, 16'd128, 16'd512, 16'd256, 31'd10 << 16,
                           31'h7fffffff);
      endcase
      if (ph == 0 || ph == 3) directed_items();
      for (int n = 0; n < RANDOM_ITEMS; n++) send(random_agent());
      drain();
    end
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

FILE: sim.f
rtl/sasf_pkg.sv
rtl/sasf_sqrt.sv
rtl/sasf_div.sv
rtl/seek_arrive_steering_force.sv
verif/testbench.sv
